FILE: design/assert_macros.svh
// Assertion macros shared by the RTL files of the stick mapping block.
// Each macro samples on clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed: %m");

// cond must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("assertion failed: %m");

`else

`define ASSERT_ALWAYS(label, prop)
`define ASSERT_NEVER(label, cond)

`endif

`endif

FILE: design/scsm_pkg.sv
// Shared constants and types of the stick centre-split mapping block.
// Used by scsm_div and stick_center_split_map_unit; depends on nothing.
package scsm_pkg;

   localparam int SAMPLE_BITS  = 12;
   localparam int OUT_BITS     = 8;
   // 127 = 2^MUL_SHIFT - 1, the span of each output half
   localparam int MUL_SHIFT    = 7;
   localparam int NUM_BITS     = SAMPLE_BITS + MUL_SHIFT;
   localparam int DIFF_BITS    = SAMPLE_BITS + 1;
   localparam int CSR_IDX_BITS = 4;

   localparam logic [SAMPLE_BITS-1:0] CAL_MIN_RST    = '0;
   localparam logic [SAMPLE_BITS-1:0] CAL_MAX_RST    = SAMPLE_BITS'(4095);
   localparam logic [SAMPLE_BITS-1:0] CAL_CENTER_RST = SAMPLE_BITS'(2048);

   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_MIN    = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_MAX    = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_CENTER = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_REVERSE    = CSR_IDX_BITS'(3);

   // per-item flags that travel alongside the divider
   typedef struct packed {
      logic upper;   // sample at or above centre: base 128
      logic neg;     // quotient is negative
      logic zero;    // segment span is zero: quotient forced to 0
      logic rev;     // invert the final value
   } side_type;

endpackage

FILE: design/scsm_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on scsm_pkg for widths and the side_type flag bundle.
module scsm_div import scsm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [NUM_BITS-1:0]    in_num,
   input  logic [SAMPLE_BITS-1:0] in_den,
   input  side_type               in_side,
   output logic                   out_valid,
   output logic [NUM_BITS-1:0]    out_quot,
   output side_type               out_side
);

   logic                   valid_ff [NUM_BITS];
   logic [SAMPLE_BITS-1:0] rem_ff   [NUM_BITS];
   logic [SAMPLE_BITS-1:0] den_ff   [NUM_BITS];
   logic [NUM_BITS-1:0]    nq_ff    [NUM_BITS];
   side_type               side_ff  [NUM_BITS];

   logic                   valid_in [NUM_BITS];
   logic [SAMPLE_BITS-1:0] rem_in   [NUM_BITS];
   logic [SAMPLE_BITS-1:0] den_in   [NUM_BITS];
   logic [NUM_BITS-1:0]    nq_in    [NUM_BITS];
   side_type               side_in  [NUM_BITS];

   // nq holds the numerator bits still to come in its top end and the
   // quotient bits found so far in its bottom end
   always_comb begin
      logic                   src_valid;
      logic [SAMPLE_BITS-1:0] src_rem;
      logic [SAMPLE_BITS-1:0] src_den;
      logic [NUM_BITS-1:0]    src_nq;
      side_type               src_side;
      logic [SAMPLE_BITS:0]   trial;
      logic [SAMPLE_BITS:0]   sub;
      logic                   ge;
      for (int i = 0; i < NUM_BITS; i++) begin
         if (i == 0) begin
            src_valid = in_valid;
            src_rem   = '0;
            src_den   = in_den;
            src_nq    = in_num;
            src_side  = in_side;
         end else begin
            src_valid = valid_ff[i-1];
            src_rem   = rem_ff[i-1];
            src_den   = den_ff[i-1];
            src_nq    = nq_ff[i-1];
            src_side  = side_ff[i-1];
         end
         trial       = {src_rem, src_nq[NUM_BITS-1]};
         sub         = trial - {1'b0, src_den};
         ge          = (trial >= {1'b0, src_den});
         valid_in[i] = src_valid;
         rem_in[i]   = ge ? sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         den_in[i]   = src_den;
         nq_in[i]    = {src_nq[NUM_BITS-2:0], ge};
         side_in[i]  = src_side;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_BITS; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_BITS; i++) begin
         rem_ff[i]  <= rem_in[i];
         den_ff[i]  <= den_in[i];
         nq_ff[i]   <= nq_in[i];
         side_ff[i] <= side_in[i];
      end
   end

   assign out_valid = valid_ff[NUM_BITS-1];
   assign out_quot  = nq_ff[NUM_BITS-1];
   assign out_side  = side_ff[NUM_BITS-1];

endmodule

FILE: design/stick_center_split_map_unit.sv
// Stick centre-split mapping block, top level.
// Depends on scsm_pkg, scsm_div and assert_macros.svh.
//
// Maps one raw stick sample to an 8-bit channel value. Pulse req_start
// with req_sample; the item is taken at a clock edge with req_start high
// and busy low. busy is high only while reset is high, so a new item may
// enter in every cycle.
// Each item passes through a clamp stage, a segment stage, a times-127
// stage, NUM_BITS divider stages that each find one quotient bit, and
// the output register. Throughput is one item per cycle.
// rsp_valid marks rsp_channel_value for exactly one cycle; the receiver
// cannot stall the block and none is needed, as the pipeline never holds.
// Calibration registers are written through csr_valid/csr_index/csr_wdata
// (csr_ready always high); the user must do so only while no item is in
// flight; the block does not enforce it. Unknown indexes are dropped. Reset
// clears the pipeline and loads min 0, max 4095, centre 2048, reverse off.
`include "assert_macros.svh"

module stick_center_split_map_unit import scsm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_start,
   input  logic [SAMPLE_BITS-1:0]  req_sample,
   output logic                    busy,
   output logic                    rsp_valid,
   output logic [OUT_BITS-1:0]     rsp_channel_value,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]  csr_wdata
);

   logic [SAMPLE_BITS-1:0] cal_min_ff;
   logic [SAMPLE_BITS-1:0] cal_max_ff;
   logic [SAMPLE_BITS-1:0] cal_center_ff;
   logic                   reverse_ff;

   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_data_ff;
   logic [SAMPLE_BITS-1:0] s1_data_in;

   logic                   s2_valid_ff;
   logic [SAMPLE_BITS-1:0] s2_mag_ff;
   logic [SAMPLE_BITS-1:0] s2_den_ff;
   side_type               s2_side_ff;
   logic [SAMPLE_BITS-1:0] s2_mag_in;
   logic [SAMPLE_BITS-1:0] s2_den_in;
   side_type               s2_side_in;

   logic                   s3_valid_ff;
   logic [NUM_BITS-1:0]    s3_num_ff;
   logic [SAMPLE_BITS-1:0] s3_den_ff;
   side_type               s3_side_ff;

   logic                   div_valid;
   logic [NUM_BITS-1:0]    div_quot;
   side_type               div_side;

   logic                   rsp_valid_ff;
   logic [OUT_BITS-1:0]    rsp_value_ff;
   logic [OUT_BITS-1:0]    rsp_value_in;

   logic                   accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = req_start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_min_ff    <= CAL_MIN_RST;
         cal_max_ff    <= CAL_MAX_RST;
         cal_center_ff <= CAL_CENTER_RST;
         reverse_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CAL_MIN:    cal_min_ff    <= csr_wdata;
            CSR_CAL_MAX:    cal_max_ff    <= csr_wdata;
            CSR_CAL_CENTER: cal_center_ff <= csr_wdata;
            CSR_REVERSE:    reverse_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamp: the lower bound wins over the upper one
   always_comb begin
      if (req_sample < cal_min_ff) begin
         s1_data_in = cal_min_ff;
      end else if (req_sample > cal_max_ff) begin
         s1_data_in = cal_max_ff;
      end else begin
         s1_data_in = req_sample;
      end
   end

   // pick the segment and split both differences into sign and magnitude
   always_comb begin
      logic                        upper;
      logic [SAMPLE_BITS-1:0]      lo;
      logic [SAMPLE_BITS-1:0]      hi;
      logic signed [DIFF_BITS-1:0] diff;
      logic signed [DIFF_BITS-1:0] den;
      logic [DIFF_BITS-1:0]        diff_abs;
      logic [DIFF_BITS-1:0]        den_abs;
      upper    = (s1_data_ff >= cal_center_ff);
      lo       = upper ? cal_center_ff : cal_min_ff;
      hi       = upper ? cal_max_ff : cal_center_ff;
      diff     = $signed({1'b0, s1_data_ff}) - $signed({1'b0, lo});
      den      = $signed({1'b0, hi}) - $signed({1'b0, lo});
      diff_abs = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
      den_abs  = den[DIFF_BITS-1] ? DIFF_BITS'(-den) : DIFF_BITS'(den);
      s2_mag_in        = diff_abs[SAMPLE_BITS-1:0];
      s2_den_in        = den_abs[SAMPLE_BITS-1:0];
      s2_side_in.upper = upper;
      s2_side_in.neg   = diff[DIFF_BITS-1] ^ den[DIFF_BITS-1];
      s2_side_in.zero  = (den == '0);
      s2_side_in.rev   = reverse_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_mag_ff  <= s2_mag_in;
      s2_den_ff  <= s2_den_in;
      s2_side_ff <= s2_side_in;
      // times 127 as shift and subtract
      s3_num_ff  <= {s2_mag_ff, MUL_SHIFT'(0)} - NUM_BITS'(s2_mag_ff);
      s3_den_ff  <= s2_den_ff;
      s3_side_ff <= s2_side_ff;
   end

   scsm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .in_den    (s3_den_ff),
      .in_side   (s3_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // only the low byte of the quotient survives the wrap
   always_comb begin
      logic [OUT_BITS-1:0] q;
      logic [OUT_BITS-1:0] mapped;
      q = div_quot[OUT_BITS-1:0];
      if (div_side.zero) begin
         q = '0;
      end else if (div_side.neg) begin
         q = OUT_BITS'(-q);
      end
      mapped       = {div_side.upper, (OUT_BITS-1)'(0)} + q;
      rsp_value_in = div_side.rev ? ~mapped : mapped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_value = rsp_value_ff;

   // an inverted range may clamp to a maximum below the minimum
   `ASSERT_NEVER(a_clamp_floor, s1_valid_ff && (cal_min_ff <= cal_max_ff) && (s1_data_ff < cal_min_ff))
   `ASSERT_ALWAYS(a_rsp_follows_div, rsp_valid_ff == $past(div_valid))
   `ASSERT_ALWAYS(a_zero_span_value, (rsp_valid_ff && $past(div_side.zero)) |-> (rsp_value_ff == 8'd0 || rsp_value_ff == 8'd127 || rsp_value_ff == 8'd128 || rsp_value_ff == 8'd255))
   `ASSERT_ALWAYS(a_zero_span_half, (rsp_valid_ff && $past(div_side.zero) && !$past(div_side.rev)) |-> (rsp_value_ff[OUT_BITS-1] == $past(div_side.upper)))

endmodule

FILE: bench/tb_stick_center_split_map_unit.sv
// Self-checking bench for stick_center_split_map_unit: clamp, centre-split map and reverse.
// Depends on scsm_pkg and the block; a local mapping function predicts each channel value.
module tb_stick_center_split_map_unit;
   import scsm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES   = 6;
   localparam int PIPE_LATENCY   = NUM_BITS + 4;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 250;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam longint OUT_SPAN   = 127;
   localparam longint UPPER_BASE = 128;
   localparam logic [OUT_BITS-1:0] OUT_MAX = 8'd255;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_TOP = '1;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_start = 1'b0;
   logic [SAMPLE_BITS-1:0]  req_sample = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic [OUT_BITS-1:0]     rsp_channel_value;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [SAMPLE_BITS-1:0]  csr_wdata = '0;

   // calibration as the block should hold it
   logic [SAMPLE_BITS-1:0]  cal_lo_q = CAL_MIN_RST;
   logic [SAMPLE_BITS-1:0]  cal_hi_q = CAL_MAX_RST;
   logic [SAMPLE_BITS-1:0]  cal_mid_q = CAL_CENTER_RST;
   logic                    reverse_q = 1'b0;

   logic [SAMPLE_BITS-1:0]  sample_queue[$];
   logic [OUT_BITS-1:0]     expected_values[$];
   int                      send_idle_pct = 0;
   int                      error_count = 0;
   int                      quiet_cycles = 0;

   stick_center_split_map_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_start         (req_start),
      .req_sample        (req_sample),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_channel_value (rsp_channel_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic logic [OUT_BITS-1:0] map_stick(input logic [SAMPLE_BITS-1:0] raw);
      longint pos, seg_lo, seg_hi, base, quot;
      logic [OUT_BITS-1:0] value;
      pos = longint'(raw);
      if (raw < cal_lo_q) begin
         pos = longint'(cal_lo_q);
      end else if (raw > cal_hi_q) begin
         pos = longint'(cal_hi_q);
      end
      if (pos < longint'(cal_mid_q)) begin
         seg_lo = longint'(cal_lo_q);
         seg_hi = longint'(cal_mid_q);
         base   = 0;
      end else begin
         seg_lo = longint'(cal_mid_q);
         seg_hi = longint'(cal_hi_q);
         base   = UPPER_BASE;
      end
      // zero span forces the quotient to 0; division truncates toward zero
      quot = (seg_hi != seg_lo) ? ((pos - seg_lo) * OUT_SPAN) / (seg_hi - seg_lo) : 0;
      value = OUT_BITS'(base + quot);
      if (reverse_q) begin
         value = OUT_MAX - value;
      end
      return value;
   endfunction

   // driver: take the next sample from the queue, idling at random
   always @(posedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
      end else begin
         if (req_start && !busy) begin
            expected_values.push_back(map_stick(req_sample));
         end
         if (!req_start || !busy) begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_start  <= 1'b1;
               req_sample <= sample_queue.pop_front();
            end else begin
               req_start <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_values.size() == 0) begin
            $error("unexpected result: channel_value actual %0d", rsp_channel_value);
            error_count++;
         end else if (rsp_channel_value !== expected_values[0]) begin
            $error("channel_value mismatch: expected %0d actual %0d",
                   expected_values[0], rsp_channel_value);
            error_count++;
            void'(expected_values.pop_front());
         end else begin
            void'(expected_values.pop_front());
         end
      end
   end

   // watchdog: count cycles without any handshake or result
   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** stick_center_split_map_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [SAMPLE_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_CAL_MIN:    cal_lo_q = data;
         CSR_CAL_MAX:    cal_hi_q = data;
         CSR_CAL_CENTER: cal_mid_q = data;
         CSR_REVERSE:    reverse_q = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_cal(input int lo, input int hi, input int mid, input logic rev);
      write_reg(CSR_CAL_MIN, SAMPLE_BITS'(lo));
      write_reg(CSR_CAL_MAX, SAMPLE_BITS'(hi));
      write_reg(CSR_CAL_CENTER, SAMPLE_BITS'(mid));
      // upper bits of the reverse write must be dropped
      write_reg(CSR_REVERSE, {(SAMPLE_BITS-1)'($urandom), rev});
   endtask

   // hold until every item is in and out, then let the pipeline settle
   task automatic drain();
      while (sample_queue.size() != 0 || req_start || expected_values.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      int anchor, pos;
      if ($urandom_range(4) < 3) begin
         return SAMPLE_BITS'($urandom);
      end
      case ($urandom_range(2))
         0: anchor = int'(cal_lo_q);
         1: anchor = int'(cal_hi_q);
         default: anchor = int'(cal_mid_q);
      endcase
      pos = anchor + int'($urandom_range(6)) - 3;
      if (pos < 0) pos = 0;
      if (pos > SAMPLE_MAX) pos = SAMPLE_MAX;
      return SAMPLE_BITS'(pos);
   endfunction

   initial begin
      int lo, hi, mid;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset calibration: ends, centre split and alternating bit patterns
      sample_queue = '{12'd0, 12'd4095, 12'd2048, 12'd2047, 12'hAAA, 12'h555};
      drain();
      set_cal(100, 4000, 2000, 1'b0);
      sample_queue = '{12'd0, 12'd100, 12'd1999, 12'd2000, 12'd4000, 12'd4095};
      drain();
      // centre equal to max: zero upper span, reversed
      set_cal(500, 3000, 3000, 1'b1);
      sample_queue = '{12'd3000, 12'd4095, 12'd2999, 12'd0};
      drain();
      // unknown indexes must leave the calibration alone
      write_reg(CSR_UNUSED_TOP, SAMPLE_BITS'($urandom));
      write_reg(CSR_IDX_BITS'($urandom_range(14, 4)), SAMPLE_BITS'($urandom));
      // inverted range: zero lower span
      set_cal(3000, 1000, 3000, 1'b0);
      sample_queue = '{12'd2000, 12'd0, 12'd4095};
      drain();
      // centre outside the range: negative quotients and wrap
      set_cal(3500, 500, 4095, 1'b0);
      sample_queue = '{12'd0, 12'd2000, 12'd4095};
      drain();
      set_cal(2000, 4095, 0, 1'b1);
      sample_queue = '{12'd2500};
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_cal(int'(CAL_MIN_RST), int'(CAL_MAX_RST), int'(CAL_CENTER_RST), 1'b0);
            1, 2: begin
               lo  = $urandom_range(1500);
               hi  = $urandom_range(SAMPLE_MAX, 2600);
               mid = $urandom_range(hi, lo);
               set_cal(lo, hi, mid, phase[0] ? 1'b0 : 1'b1);
            end
            3: set_cal(0, SAMPLE_MAX, 0, 1'b1);
            4: set_cal(0, SAMPLE_MAX, SAMPLE_MAX, 1'b0);
            5: set_cal($urandom_range(SAMPLE_MAX), $urandom_range(SAMPLE_MAX),
                       $urandom_range(SAMPLE_MAX), 1'($urandom));
            6: begin
               mid = $urandom_range(SAMPLE_MAX);
               set_cal(mid, mid, mid, 1'($urandom));
            end
            default: set_cal(SAMPLE_MAX, 0, $urandom_range(SAMPLE_MAX), 1'b1);
         endcase
         case (phase % 3)
            0: send_idle_pct = 0;
            1: send_idle_pct = 85;
            default: send_idle_pct = 32;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++)
            sample_queue.push_back(pick_sample());
         drain();
      end

      if (error_count == 0) begin
         $display("** stick_center_split_map_unit: PASSED **");
      end else begin
         $display("** stick_center_split_map_unit: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/scsm_pkg.sv
design/scsm_div.sv
design/stick_center_split_map_unit.sv
bench/tb_stick_center_split_map_unit.sv
